/* hdl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Types, widths and constants shared by the corner interior angle pipeline.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int NORM_TOP   = 40;
  localparam int SHIFT_W    = 6;
  localparam int CW         = 46;
  localparam int ZW         = 26;
  localparam int OUT_W      = FRAC_BITS + 9;
  localparam int STEPS      = 23;
  localparam int RND_SH     = 16 - FRAC_BITS;

  localparam logic signed [ZW-1:0] DEG90_Q16  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] RND_HALF   = ZW'((1 << RND_SH) >> 1);
  localparam logic signed [ZW-1:0] ANG180     = ZW'(180 << FRAC_BITS);
  localparam logic [OUT_W-1:0]     ANG360     = OUT_W'(360 << FRAC_BITS);

  typedef enum logic [1:0] {
    ZK_CORDIC,
    ZK_ZERO,
    ZK_RIGHT,
    ZK_STRAIGHT
  } zkind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner_x;
    logic signed [COORD_BITS-1:0] corner_y;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic signed [COORD_BITS-1:0] next_x;
    logic signed [COORD_BITS-1:0] next_y;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle_deg_q8;
    logic             degenerate;
  } out_res_t;

  typedef struct packed {
    logic   degen;
    logic   reflex;
    logic   add90;
    zkind_t kind;
  } cia_tag_t;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = ZW'(2949120);
      1:       r = ZW'(1740967);
      2:       r = ZW'(919879);
      3:       r = ZW'(466945);
      4:       r = ZW'(234379);
      5:       r = ZW'(117304);
      6:       r = ZW'(58666);
      7:       r = ZW'(29335);
      8:       r = ZW'(14668);
      9:       r = ZW'(7334);
      10:      r = ZW'(3667);
      11:      r = ZW'(1833);
      12:      r = ZW'(917);
      13:      r = ZW'(458);
      14:      r = ZW'(229);
      15:      r = ZW'(115);
      16:      r = ZW'(57);
      17:      r = ZW'(29);
      18:      r = ZW'(14);
      19:      r = ZW'(7);
      20:      r = ZW'(4);
      21:      r = ZW'(2);
      22:      r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/cia_cordic_stage.sv */
// ----------------------------------------------------------------------------
// cia_cordic_stage
// One registered CORDIC vectoring step: rotate toward y = 0, accumulate angle.
// ----------------------------------------------------------------------------
module cia_cordic_stage
  import cia_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  cia_tag_t             in_tag,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output cia_tag_t             out_tag
);

  localparam logic signed [ZW-1:0] ATAN = atan_q16(STEP);

  logic                 valid_r;
  logic signed [CW-1:0] x_r, x_nxt;
  logic signed [CW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  cia_tag_t             tag_r;

  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
    if (in_y > 0) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ATAN;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= in_tag;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_tag   = tag_r;

endmodule

/* hdl/corner_interior_angle_unit.sv */
// ----------------------------------------------------------------------------
// corner_interior_angle_unit
// The result passes through stages s1 to s6, the CORDIC chain, f1, f2 and the output register.
// Throughput: one request per cycle; busy stays low, set by a fully
//   pipelined 23-stage CORDIC with one step per register stage.
// Reset clears all valid bits, so no result is strobed until a request has passed through.
// ----------------------------------------------------------------------------
module corner_interior_angle_unit
  import cia_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  // stage 1: edge and orientation differences
  logic                     s1_valid_r;
  logic signed [DIFF_W-1:0] s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic signed [DIFF_W-1:0] s1_oa0_r, s1_oa1_r, s1_ob0_r, s1_ob1_r;
  logic                     s1_degen_r;

  // stage 2: products
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_xx_r, s2_yy_r, s2_xy_r, s2_yx_r, s2_a_r, s2_b_r;
  logic                     s2_degen_r;

  // stage 3: dot, cross, orientation
  logic                     s3_valid_r;
  logic signed [SUM_W-1:0]  s3_dot_r, s3_cross_r;
  logic                     s3_reflex_r;
  logic                     s3_degen_r;

  // stage 4: magnitudes, swap, case selection
  logic                     s4_valid_r;
  logic [MAG_W-1:0]         s4_x_r, s4_y_r;
  cia_tag_t                 s4_tag_r, s4_tag_nxt;
  logic [MAG_W-1:0]         s4_x_nxt, s4_y_nxt;

  // stage 5: leading one search
  logic                     s5_valid_r;
  logic [MAG_W-1:0]         s5_x_r, s5_y_r;
  logic [SHIFT_W-1:0]       s5_sh_r, s5_sh_nxt;
  cia_tag_t                 s5_tag_r;

  // stage 6: normalize
  logic                     s6_valid_r;
  logic signed [CW-1:0]     s6_x_r, s6_y_r;
  cia_tag_t                 s6_tag_r;

  // CORDIC chain
  logic                     c_valid [STEPS+1];
  logic signed [CW-1:0]     c_x     [STEPS+1];
  logic signed [CW-1:0]     c_y     [STEPS+1];
  logic signed [ZW-1:0]     c_z     [STEPS+1];
  cia_tag_t                 c_tag   [STEPS+1];

  // finishing stages
  logic                     f1_valid_r;
  logic signed [ZW-1:0]     f1_z_r, f1_z_nxt;
  cia_tag_t                 f1_tag_r;
  logic                     f2_valid_r;
  logic [OUT_W-1:0]         f2_ang_r, f2_ang_nxt;
  cia_tag_t                 f2_tag_r;
  logic                     out_valid_r;
  out_res_t                 out_res_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      f1_valid_r  <= 1'b0;
      f2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= start & ~busy;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      f1_valid_r  <= c_valid[STEPS];
      f2_valid_r  <= f1_valid_r;
      out_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x1_r    <= sx(in_req.prev_x) - sx(in_req.corner_x);
    s1_y1_r    <= sx(in_req.prev_y) - sx(in_req.corner_y);
    s1_x2_r    <= sx(in_req.next_x) - sx(in_req.corner_x);
    s1_y2_r    <= sx(in_req.next_y) - sx(in_req.corner_y);
    s1_oa0_r   <= sx(in_req.corner_x) - sx(in_req.prev_x);
    s1_oa1_r   <= sx(in_req.next_y) - sx(in_req.prev_y);
    s1_ob0_r   <= sx(in_req.corner_y) - sx(in_req.prev_y);
    s1_ob1_r   <= sx(in_req.next_x) - sx(in_req.prev_x);
    s1_degen_r <= ((in_req.prev_x == in_req.corner_x) && (in_req.prev_y == in_req.corner_y))
               || ((in_req.next_x == in_req.corner_x) && (in_req.next_y == in_req.corner_y));
  end

  always_ff @(posedge clk) begin
    s2_xx_r    <= s1_x1_r * s1_x2_r;
    s2_yy_r    <= s1_y1_r * s1_y2_r;
    s2_xy_r    <= s1_x1_r * s1_y2_r;
    s2_yx_r    <= s1_y1_r * s1_x2_r;
    s2_a_r     <= s1_oa0_r * s1_oa1_r;
    s2_b_r     <= s1_ob0_r * s1_ob1_r;
    s2_degen_r <= s1_degen_r;
  end

  always_ff @(posedge clk) begin
    s3_dot_r    <= SUM_W'(s2_xx_r) + SUM_W'(s2_yy_r);
    s3_cross_r  <= SUM_W'(s2_xy_r) - SUM_W'(s2_yx_r);
    s3_reflex_r <= !(s2_a_r < s2_b_r);
    s3_degen_r  <= s2_degen_r;
  end

  always_comb begin
    logic             dneg;
    logic [MAG_W-1:0] dmag;
    logic [MAG_W-1:0] cmag;
    dneg = s3_dot_r[SUM_W-1];
    dmag = dneg ? MAG_W'(-s3_dot_r) : MAG_W'(s3_dot_r);
    cmag = s3_cross_r[SUM_W-1] ? MAG_W'(-s3_cross_r) : MAG_W'(s3_cross_r);
    s4_tag_nxt.degen  = s3_degen_r;
    s4_tag_nxt.reflex = s3_reflex_r;
    s4_tag_nxt.add90  = dneg;
    if (cmag == '0) begin
      s4_tag_nxt.kind = dneg ? ZK_STRAIGHT : ZK_ZERO;
    end else if (dmag == '0) begin
      s4_tag_nxt.kind = ZK_RIGHT;
    end else begin
      s4_tag_nxt.kind = ZK_CORDIC;
    end
    s4_x_nxt = dneg ? cmag : dmag;
    s4_y_nxt = dneg ? dmag : cmag;
  end

  always_ff @(posedge clk) begin
    s4_x_r   <= s4_x_nxt;
    s4_y_r   <= s4_y_nxt;
    s4_tag_r <= s4_tag_nxt;
  end

  always_comb begin
    logic [MAG_W-1:0]   v;
    logic [SHIFT_W-1:0] msb;
    v   = s4_x_r | s4_y_r;
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) msb = SHIFT_W'(i);
    end
    s5_sh_nxt = SHIFT_W'(NORM_TOP) - msb;
  end

  always_ff @(posedge clk) begin
    s5_x_r   <= s4_x_r;
    s5_y_r   <= s4_y_r;
    s5_sh_r  <= s5_sh_nxt;
    s5_tag_r <= s4_tag_r;
  end

  always_ff @(posedge clk) begin
    s6_x_r   <= $signed(CW'(s5_x_r) << s5_sh_r);
    s6_y_r   <= $signed(CW'(s5_y_r) << s5_sh_r);
    s6_tag_r <= s5_tag_r;
  end

  assign c_valid[0] = s6_valid_r;
  assign c_x[0]     = s6_x_r;
  assign c_y[0]     = s6_y_r;
  assign c_z[0]     = '0;
  assign c_tag[0]   = s6_tag_r;

  for (genvar g = 0; g < STEPS; g++) begin : g_cordic
    cia_cordic_stage #(
      .STEP(g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (c_valid[g]),
      .in_x     (c_x[g]),
      .in_y     (c_y[g]),
      .in_z     (c_z[g]),
      .in_tag   (c_tag[g]),
      .out_valid(c_valid[g+1]),
      .out_x    (c_x[g+1]),
      .out_y    (c_y[g+1]),
      .out_z    (c_z[g+1]),
      .out_tag  (c_tag[g+1])
    );
  end

  always_comb begin
    case (c_tag[STEPS].kind)
      ZK_ZERO:     f1_z_nxt = '0;
      ZK_RIGHT:    f1_z_nxt = DEG90_Q16;
      ZK_STRAIGHT: f1_z_nxt = DEG180_Q16;
      default:     f1_z_nxt = c_z[STEPS] + (c_tag[STEPS].add90 ? DEG90_Q16 : ZW'(0));
    endcase
  end

  always_ff @(posedge clk) begin
    f1_z_r   <= f1_z_nxt;
    f1_tag_r <= c_tag[STEPS];
  end

  always_comb begin
    logic signed [ZW-1:0] a;
    a = (f1_z_r + RND_HALF) >>> RND_SH;
    if (f1_z_r < 0) begin
      f2_ang_nxt = '0;
    end else if (a > ANG180) begin
      f2_ang_nxt = OUT_W'(ANG180);
    end else begin
      f2_ang_nxt = OUT_W'(a);
    end
  end

  always_ff @(posedge clk) begin
    f2_ang_r <= f2_ang_nxt;
    f2_tag_r <= f1_tag_r;
  end

  always_ff @(posedge clk) begin
    out_res_r.degenerate <= f2_tag_r.degen;
    if (f2_tag_r.degen) begin
      out_res_r.angle_deg_q8 <= '0;
    end else if (f2_tag_r.reflex) begin
      out_res_r.angle_deg_q8 <= ANG360 - f2_ang_r;
    end else begin
      out_res_r.angle_deg_q8 <= f2_ang_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r, 31))
    else $error("result strobe without matching request");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.angle_deg_q8 <= ANG360)
    else $error("angle above full turn");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_valid_r && s5_tag_r.kind == ZK_CORDIC && !s5_tag_r.degen)
      |-> ((s5_x_r | s5_y_r) != '0))
    else $error("zero vector sent to rotation");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (s6_valid_r && s6_tag_r.kind == ZK_CORDIC && !s6_tag_r.degen)
      |-> ((s6_x_r | s6_y_r) >> NORM_TOP) == CW'(1))
    else $error("normalized vector out of range");

endmodule
